/* hdl/fls_pkg.sv */
// ----------------------------------------------------------------------------
// fls_pkg
// Shared types and codes for the free-list stack slot allocator.
// ----------------------------------------------------------------------------
package fls_pkg;

	localparam int IDX_W   = 6;
	localparam int COUNT_W = 7;
	localparam int STAT_W  = 2;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FAIL    = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_READ,
		S_PUSH,
		S_FINISH
	} fls_state_t;

	// Outcome of a captured request, decided against the current depth.
	typedef enum logic [1:0] {
		CLS_IGNORE,
		CLS_ERROR,
		CLS_ALLOC,
		CLS_FREE
	} fls_cls_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic read_done;
		logic push;
		logic load_out;
	} fls_cmd_t;

	typedef struct packed {
		fls_cls_t cls;
		logic     push_last;
		logic     out_room;
	} fls_stat_t;

endpackage

/* hdl/fls_ctrl.sv */
// ----------------------------------------------------------------------------
// fls_ctrl
// Sequencer for the allocator: accepts a request, steps the datapath
// through evaluation, the stack read or the push loop, and hands off.
// ----------------------------------------------------------------------------
module fls_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  fls_pkg::fls_stat_t stat,
	output fls_pkg::fls_cmd_t  cmd
);
	import fls_pkg::*;

	fls_state_t state_q;
	fls_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				case (stat.cls)
					CLS_ALLOC: state_d = S_READ;
					CLS_FREE:  state_d = S_PUSH;
					default:   state_d = S_FINISH;
				endcase
			end
			S_READ: begin
				state_d = S_FINISH;
			end
			S_PUSH: begin
				if (stat.push_last) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (stat.out_room) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			S_EVAL:   cmd.eval      = 1'b1;
			S_READ:   cmd.read_done = 1'b1;
			S_PUSH:   cmd.push      = 1'b1;
			S_FINISH: cmd.load_out  = stat.out_room;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* hdl/fls_datapath.sv */
// ----------------------------------------------------------------------------
// fls_datapath
// Free stack memory, depth and low-water mark, request registers and
// the output register.
// ----------------------------------------------------------------------------
module fls_datapath #(
	parameter int POOL_SLOTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fls_pkg::fls_cmd_t             cmd,
	output fls_pkg::fls_stat_t            stat,
	input  logic                          mode,
	input  logic [fls_pkg::COUNT_W-1:0]   slot_count,
	input  logic [fls_pkg::IDX_W-1:0]     base_slot,
	input  logic                          base_is_null,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [fls_pkg::IDX_W-1:0]     granted_slot,
	output logic [fls_pkg::STAT_W-1:0]    status,
	output logic [fls_pkg::COUNT_W-1:0]   free_left
);
	import fls_pkg::*;

	localparam int AW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int DW = $clog2(POOL_SLOTS + 1);
	localparam int SW = ((DW > COUNT_W) ? DW : COUNT_W) + 1;

	logic [IDX_W-1:0] mem [POOL_SLOTS];
	logic [IDX_W-1:0] rdata_q;

	logic               mode_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [IDX_W-1:0]   base_q;
	logic               null_q;

	logic [DW-1:0] depth_q;
	logic [DW-1:0] low_q;
	logic          use_orig_q;

	logic [IDX_W-1:0]  res_slot_q;
	logic [STAT_W-1:0] res_status_q;

	logic              rsp_valid_q;
	logic [IDX_W-1:0]  granted_q;
	logic [STAT_W-1:0] status_q;
	logic [COUNT_W-1:0] free_left_q;

	logic [SW-1:0]       n_ext;
	logic [SW-1:0]       d_ext;
	logic [SW-1:0]       diff;
	logic [DW-1:0]       new_depth;
	logic [DW+IDX_W-1:0] depth_wide;
	logic [DW+COUNT_W-1:0] depth_left;
	logic [IDX_W-1:0]    depth_idx;
	fls_cls_t            cls;
	logic                rd_en;

	assign n_ext      = SW'(cnt_q);
	assign d_ext      = SW'(depth_q);
	assign diff       = d_ext - n_ext;
	assign new_depth  = diff[DW-1:0];
	assign depth_wide = {{IDX_W{1'b0}}, depth_q};
	assign depth_idx  = depth_wide[IDX_W-1:0];
	assign depth_left = {{COUNT_W{1'b0}}, depth_q};

	always_comb begin
		if (mode_q == MODE_ALLOC) begin
			if (cnt_q == '0) begin
				cls = CLS_IGNORE;
			end else if (n_ext > d_ext) begin
				cls = CLS_ERROR;
			end else begin
				cls = CLS_ALLOC;
			end
		end else begin
			if (cnt_q == '0 || null_q) begin
				cls = CLS_IGNORE;
			end else if (d_ext + n_ext > SW'(POOL_SLOTS)) begin
				cls = CLS_ERROR;
			end else begin
				cls = CLS_FREE;
			end
		end
	end

	assign rd_en          = cmd.eval && (cls == CLS_ALLOC);
	assign stat.cls       = cls;
	assign stat.push_last = (cnt_q == COUNT_W'(1));
	assign stat.out_room  = !rsp_valid_q || rsp_ready;

	// Stack memory: one push per cycle, one registered read per allocate.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[depth_q[AW-1:0]] <= base_q;
		end
		if (rd_en) begin
			rdata_q <= mem[new_depth[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			cnt_q  <= slot_count;
			base_q <= base_slot;
			null_q <= base_is_null;
		end else if (cmd.push) begin
			cnt_q  <= cnt_q - COUNT_W'(1);
			base_q <= base_q + IDX_W'(1);
		end
	end

	// Entries below the lowest depth ever reached have never been pushed,
	// so the memory holds nothing valid there and they are produced from the index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DW'(POOL_SLOTS);
			low_q   <= DW'(POOL_SLOTS);
		end else begin
			if (rd_en) begin
				depth_q <= new_depth;
				if (new_depth < low_q) begin
					low_q <= new_depth;
				end
			end else if (cmd.push) begin
				depth_q <= depth_q + DW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			use_orig_q <= (new_depth < low_q);
		end
		if (cmd.eval) begin
			res_slot_q <= '0;
			case (cls)
				CLS_IGNORE: res_status_q <= STAT_IGNORED;
				CLS_ERROR:  res_status_q <= STAT_FAIL;
				default:    res_status_q <= STAT_DONE;
			endcase
		end else if (cmd.read_done) begin
			res_slot_q <= use_orig_q ? depth_idx : rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			granted_q   <= res_slot_q;
			status_q    <= res_status_q;
			free_left_q <= depth_left[COUNT_W-1:0];
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign granted_slot = granted_q;
	assign status       = status_q;
	assign free_left    = free_left_q;

endmodule

/* hdl/free_list_stack_slot_allocator_core.sv */
// ----------------------------------------------------------------------------
// free_list_stack_slot_allocator_core
// Slot pool managed by a stack of free slot indices: allocate and free.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | mode, slot_count, base_slot,
//           |           |                      | base_is_null
//   rsp     | out       | rsp_valid/rsp_ready  | granted_slot, status, free_left
//
// An allocate runs from acceptance to the response register through
// evaluate, registered stack read and finish. A free pushes one stack
// entry per cycle, one per slot of slot_count, between evaluate and finish.
// Ignored and failed requests go from evaluate to finish. No clearing pass
// follows reset: a low-water mark on the depth stands in for the initial
// stack contents. A new request is taken while the previous response waits;
// a stalled response holds the sequencer only when the next one is ready.
// ----------------------------------------------------------------------------
module free_list_stack_slot_allocator_core #(
	parameter int POOL_SLOTS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic                        mode,
	input  logic [fls_pkg::COUNT_W-1:0] slot_count,
	input  logic [fls_pkg::IDX_W-1:0]   base_slot,
	input  logic                        base_is_null,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [fls_pkg::IDX_W-1:0]   granted_slot,
	output logic [fls_pkg::STAT_W-1:0]  status,
	output logic [fls_pkg::COUNT_W-1:0] free_left
);
	import fls_pkg::*;

	fls_cmd_t  cmd;
	fls_stat_t stat;

	fls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fls_datapath #(
		.POOL_SLOTS (POOL_SLOTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.mode         (mode),
		.slot_count   (slot_count),
		.base_slot    (base_slot),
		.base_is_null (base_is_null),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.granted_slot (granted_slot),
		.status       (status),
		.free_left    (free_left)
	);

	// A request just taken is still being worked on in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while previous one still in flight");

	// Only a successful request hands out a slot.
	a_no_slot_on_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != STAT_DONE) |-> (granted_slot == '0))
		else $error("granted slot nonzero on ignored or failed request");

	// A waiting response is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rsp_valid || rsp_ready))
		else $error("response register loaded while previous response pending");

endmodule
